/* sv/trmc_pkg.sv */
// Shared constants, types and the control store for the timed revolution motor controller.
package trmc_pkg;

    // Default encoder counter width
    localparam int ENCODER_BITS_DEF = 16;

    // Field and register widths
    localparam int CFG_W   = 20;
    localparam int DUR_W   = 20;
    localparam int THR_W   = 10;
    localparam int DRV_W   = 8;
    localparam int GAIN_W  = 4;
    localparam int TPR_W   = 16;
    localparam int SEN_W   = 10;
    localparam int PROD_W  = DUR_W + TPR_W;
    localparam int OUT_W   = 56;
    localparam int IDX_W   = 3;

    // Item kinds
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_HOME   = 2'd2;
    localparam logic [1:0] OP_ABORT  = 2'd3;

    // Operating modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_HOMING  = 2'd1;
    localparam logic [1:0] MODE_RUNNING = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_DURATION  = 3'd0;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_DRIVE = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN      = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOME_DRV  = 3'd4;
    localparam logic [IDX_W-1:0] REG_TICKS     = 3'd5;

    // Configuration reset values
    localparam logic [DUR_W-1:0]  DURATION_RST  = 20'd60000;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 10'd800;
    localparam logic [DRV_W-1:0]  MIN_DRIVE_RST = 8'd110;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 4'd2;
    localparam logic [DRV_W-1:0]  HOME_DRV_RST  = 8'd130;
    localparam logic [TPR_W-1:0]  TICKS_RST     = 16'd703;

    localparam logic [DRV_W-1:0] DRIVE_MAX   = 8'd255;
    localparam logic [DUR_W-1:0] ELAPSED_MAX = 20'hFFFFF;

    // Micro-operations
    localparam int UOP_W = 4;
    localparam logic [UOP_W-1:0] UOP_FETCH  = 4'd0;
    localparam logic [UOP_W-1:0] UOP_DECODE = 4'd1;
    localparam logic [UOP_W-1:0] UOP_INC    = 4'd2;
    localparam logic [UOP_W-1:0] UOP_MUL    = 4'd3;
    localparam logic [UOP_W-1:0] UOP_DIV    = 4'd4;
    localparam logic [UOP_W-1:0] UOP_ERR    = 4'd5;
    localparam logic [UOP_W-1:0] UOP_DRIVE  = 4'd6;
    localparam logic [UOP_W-1:0] UOP_EVENT  = 4'd7;
    localparam logic [UOP_W-1:0] UOP_EMIT   = 4'd8;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEVER       = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS      = 3'd1;
    localparam logic [COND_W-1:0] COND_NO_ITEM     = 3'd2;
    localparam logic [COND_W-1:0] COND_NOT_RUNTICK = 3'd3;
    localparam logic [COND_W-1:0] COND_DIV_MORE    = 3'd4;
    localparam logic [COND_W-1:0] COND_OUT_BUSY    = 3'd5;

    // Program addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_FETCH  = 4'd0;
    localparam logic [PC_W-1:0] STEP_DECODE = 4'd1;
    localparam logic [PC_W-1:0] STEP_INC    = 4'd2;
    localparam logic [PC_W-1:0] STEP_MUL    = 4'd3;
    localparam logic [PC_W-1:0] STEP_DIV    = 4'd4;
    localparam logic [PC_W-1:0] STEP_ERR    = 4'd5;
    localparam logic [PC_W-1:0] STEP_DRIVE  = 4'd6;
    localparam logic [PC_W-1:0] STEP_EVENT  = 4'd7;
    localparam logic [PC_W-1:0] STEP_EMIT   = 4'd8;

    // Divider iteration count
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

    // One control word
    typedef struct packed {
        logic [UOP_W-1:0]  uop;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   jump;
        logic              wrap;
    } ucode_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic item_valid;
        logic run_tick;
        logic div_more;
        logic out_busy;
    } seq_status_t;

    // Control store: a taken condition jumps, otherwise the step advances or wraps to fetch.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            STEP_FETCH:  w = '{UOP_FETCH,  COND_NO_ITEM,     STEP_FETCH, 1'b0};
            STEP_DECODE: w = '{UOP_DECODE, COND_NOT_RUNTICK, STEP_EVENT, 1'b0};
            STEP_INC:    w = '{UOP_INC,    COND_NEVER,       STEP_FETCH, 1'b0};
            STEP_MUL:    w = '{UOP_MUL,    COND_NEVER,       STEP_FETCH, 1'b0};
            STEP_DIV:    w = '{UOP_DIV,    COND_DIV_MORE,    STEP_DIV,   1'b0};
            STEP_ERR:    w = '{UOP_ERR,    COND_NEVER,       STEP_FETCH, 1'b0};
            STEP_DRIVE:  w = '{UOP_DRIVE,  COND_ALWAYS,      STEP_EMIT,  1'b0};
            STEP_EVENT:  w = '{UOP_EVENT,  COND_NEVER,       STEP_FETCH, 1'b0};
            STEP_EMIT:   w = '{UOP_EMIT,   COND_OUT_BUSY,    STEP_EMIT,  1'b1};
            default:     w = '{UOP_DECODE, COND_NEVER,       STEP_FETCH, 1'b1};
        endcase
        return w;
    endfunction

endpackage

/* sv/trmc_seq.sv */
// Microprogram sequencer: step counter, control store and conditional jumps.
module trmc_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  trmc_pkg::seq_status_t status,
    output trmc_pkg::ucode_t      ctrl
);

    logic [trmc_pkg::PC_W-1:0] pc_reg;
    logic [trmc_pkg::PC_W-1:0] pc_next;
    logic                      taken;

    // Current control word
    assign ctrl = trmc_pkg::ucode_rom(pc_reg);

    // Jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            trmc_pkg::COND_NEVER:       taken = 1'b0;
            trmc_pkg::COND_ALWAYS:      taken = 1'b1;
            trmc_pkg::COND_NO_ITEM:     taken = !status.item_valid;
            trmc_pkg::COND_NOT_RUNTICK: taken = !status.run_tick;
            trmc_pkg::COND_DIV_MORE:    taken = status.div_more;
            trmc_pkg::COND_OUT_BUSY:    taken = status.out_busy;
            default:                    taken = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        if (taken)
        begin
            pc_next = ctrl.jump;
        end
        else if (ctrl.wrap)
        begin
            pc_next = trmc_pkg::STEP_FETCH;
        end
        else
        begin
            pc_next = pc_reg + trmc_pkg::PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= trmc_pkg::STEP_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* sv/timed_revolution_motor_controller_top.sv */
// Top level: configuration, datapath and output register of the timed revolution controller.
// Steps: a running tick goes fetch, decode, increment, multiply, the 16-step restoring divider
// for the target, error and drive, then emit registers its result; any other item goes fetch,
// decode, event, emit. Input is taken only at fetch; a stalled output holds the emit step.
// Reset: rst_n is asynchronous, active low; it clears mode, calibration, elapsed time and
// the sequencer and loads every configuration register with its default.
module timed_revolution_motor_controller_top #(
    parameter int ENCODER_BITS = trmc_pkg::ENCODER_BITS_DEF,
    parameter int IN_W         = ((ENCODER_BITS + trmc_pkg::SEN_W + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [trmc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [trmc_pkg::CFG_W-1:0]       cfg_wdata,
    // Input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_W-1:0]                  s_tdata,   // encoder_count, sensor_level
    input  logic [1:0]                       s_tuser,   // op
    // Result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [trmc_pkg::OUT_W-1:0]       m_tdata    // drive, mode, calibrated,
                                                        // encoder_clear, finished,
                                                        // target_ticks, remaining_ms
);

    localparam int CMP_W = ((ENCODER_BITS > trmc_pkg::TPR_W) ? ENCODER_BITS : trmc_pkg::TPR_W)
                           + 1;
    localparam logic [ENCODER_BITS-1:0] ENC_HALF = {1'b1, {(ENCODER_BITS - 1){1'b0}}};
    localparam int GAIN_PROD_W = trmc_pkg::TPR_W + trmc_pkg::GAIN_W;
    localparam int SUM_W       = GAIN_PROD_W + 1;

    // Configuration registers
    logic [trmc_pkg::DUR_W-1:0]  duration_reg;
    logic [trmc_pkg::THR_W-1:0]  threshold_reg;
    logic [trmc_pkg::DRV_W-1:0]  min_drive_reg;
    logic [trmc_pkg::GAIN_W-1:0] gain_reg;
    logic [trmc_pkg::DRV_W-1:0]  home_drive_reg;
    logic [trmc_pkg::TPR_W-1:0]  ticks_reg;

    // Control state
    logic [1:0]                  mode_reg, mode_next;
    logic                        home_reg, home_next;
    logic [trmc_pkg::DUR_W-1:0]  elapsed_reg, elapsed_next;
    logic [trmc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    // Item and working registers
    logic [1:0]                  op_reg, op_next;
    logic [ENCODER_BITS-1:0]     enc_reg, enc_next;
    logic [trmc_pkg::SEN_W-1:0]  sen_reg, sen_next;
    logic [trmc_pkg::DUR_W-1:0]  div_rem_reg, div_rem_next;
    logic [trmc_pkg::TPR_W-1:0]  div_quo_reg, div_quo_next;
    logic [trmc_pkg::TPR_W-1:0]  err_reg, err_next;
    logic                        lag_reg, lag_next;

    // Result registers
    logic [trmc_pkg::DRV_W-1:0]  drive_reg, drive_next;
    logic                        clear_reg, clear_next;
    logic                        fin_reg, fin_next;
    logic [trmc_pkg::TPR_W-1:0]  tgt_reg, tgt_next;
    logic [trmc_pkg::DUR_W-1:0]  rem_ms_reg, rem_ms_next;
    logic [trmc_pkg::OUT_W-1:0]  out_data_reg, out_data_next;

    // Datapath terms
    logic [trmc_pkg::DUR_W-1:0]  t_min;
    logic [trmc_pkg::PROD_W-1:0] prod;
    logic [trmc_pkg::DUR_W:0]    shifted;
    logic [trmc_pkg::DUR_W:0]    sub;
    logic                        ge;
    logic [trmc_pkg::TPR_W-1:0]  target;
    logic [ENCODER_BITS-1:0]     pos;
    logic [CMP_W-1:0]            tgt_ext, pos_ext, diff;
    logic [GAIN_PROD_W-1:0]      gain_prod;
    logic [SUM_W-1:0]            drive_sum;
    logic [trmc_pkg::DRV_W-1:0]  drive_sat;

    trmc_pkg::ucode_t            ctrl;
    trmc_pkg::seq_status_t       status;

    // Sequencer
    assign status.item_valid = s_tvalid;
    assign status.run_tick   = (op_reg == trmc_pkg::OP_TICK)
                               && (mode_reg == trmc_pkg::MODE_RUNNING);
    assign status.div_more   = (cnt_reg != trmc_pkg::DIV_LAST);
    assign status.out_busy   = m_tvalid_reg && !m_tready;

    trmc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign s_tready = (ctrl.uop == trmc_pkg::UOP_FETCH);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // Target multiply and one restoring-division step
    assign t_min   = (elapsed_reg < duration_reg) ? elapsed_reg : duration_reg;
    assign prod    = trmc_pkg::PROD_W'(t_min) * trmc_pkg::PROD_W'(ticks_reg);
    assign shifted = {div_rem_reg, div_quo_reg[trmc_pkg::TPR_W-1]};
    assign sub     = shifted - {1'b0, duration_reg};
    assign ge      = (shifted >= {1'b0, duration_reg});
    assign target  = (duration_reg == '0) ? ticks_reg : div_quo_reg;

    // Folded encoder position and lag against the target
    assign pos     = (enc_reg > ENC_HALF) ? (~enc_reg + ENCODER_BITS'(1)) : enc_reg;
    assign tgt_ext = CMP_W'(target);
    assign pos_ext = CMP_W'(pos);
    assign diff    = tgt_ext - pos_ext;

    // Proportional drive with saturation
    assign gain_prod = GAIN_PROD_W'(gain_reg) * GAIN_PROD_W'(err_reg);
    assign drive_sum = {1'b0, gain_prod} + SUM_W'(min_drive_reg);
    assign drive_sat = (drive_sum > SUM_W'(trmc_pkg::DRIVE_MAX))
                       ? trmc_pkg::DRIVE_MAX : drive_sum[trmc_pkg::DRV_W-1:0];

    // Micro-operation execution
    always_comb
    begin
        mode_next     = mode_reg;
        home_next     = home_reg;
        elapsed_next  = elapsed_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        enc_next      = enc_reg;
        sen_next      = sen_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        err_next      = err_reg;
        lag_next      = lag_reg;
        drive_next    = drive_reg;
        clear_next    = clear_reg;
        fin_next      = fin_reg;
        tgt_next      = tgt_reg;
        rem_ms_next   = rem_ms_reg;
        out_data_next = out_data_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (ctrl.uop)
            trmc_pkg::UOP_FETCH:
            begin
                if (s_tvalid)
                begin
                    op_next  = s_tuser;
                    enc_next = s_tdata[ENCODER_BITS-1:0];
                    sen_next = s_tdata[ENCODER_BITS+trmc_pkg::SEN_W-1:ENCODER_BITS];
                end
            end
            trmc_pkg::UOP_DECODE:
            begin
            end
            trmc_pkg::UOP_INC:
            begin
                if (elapsed_reg != trmc_pkg::ELAPSED_MAX)
                begin
                    elapsed_next = elapsed_reg + trmc_pkg::DUR_W'(1);
                end
            end
            trmc_pkg::UOP_MUL:
            begin
                div_rem_next = prod[trmc_pkg::PROD_W-1:trmc_pkg::TPR_W];
                div_quo_next = prod[trmc_pkg::TPR_W-1:0];
                cnt_next     = '0;
            end
            trmc_pkg::UOP_DIV:
            begin
                div_rem_next = ge ? sub[trmc_pkg::DUR_W-1:0] : shifted[trmc_pkg::DUR_W-1:0];
                div_quo_next = {div_quo_reg[trmc_pkg::TPR_W-2:0], ge};
                cnt_next     = cnt_reg + trmc_pkg::DIV_CNT_W'(1);
            end
            trmc_pkg::UOP_ERR:
            begin
                tgt_next    = target;
                lag_next    = (tgt_ext > pos_ext);
                err_next    = diff[trmc_pkg::TPR_W-1:0];
                fin_next    = (elapsed_reg >= duration_reg);
                rem_ms_next = (elapsed_reg < duration_reg) ? (duration_reg - elapsed_reg) : '0;
            end
            trmc_pkg::UOP_DRIVE:
            begin
                clear_next = 1'b0;
                if (fin_reg)
                begin
                    drive_next = '0;
                    mode_next  = trmc_pkg::MODE_IDLE;
                end
                else
                begin
                    drive_next = lag_reg ? drive_sat : '0;
                end
            end
            trmc_pkg::UOP_EVENT:
            begin
                drive_next  = '0;
                clear_next  = 1'b0;
                fin_next    = 1'b0;
                tgt_next    = '0;
                rem_ms_next = '0;
                unique case (op_reg)
                    trmc_pkg::OP_TICK:
                    begin
                        // Running ticks take the long path, so only homing acts here.
                        if (mode_reg == trmc_pkg::MODE_HOMING)
                        begin
                            if (sen_reg > threshold_reg)
                            begin
                                clear_next = 1'b1;
                                home_next  = 1'b1;
                                mode_next  = trmc_pkg::MODE_IDLE;
                            end
                            else
                            begin
                                drive_next = home_drive_reg;
                            end
                        end
                    end
                    trmc_pkg::OP_TOGGLE:
                    begin
                        if (mode_reg == trmc_pkg::MODE_HOMING)
                        begin
                            drive_next = home_drive_reg;
                        end
                        else if (mode_reg == trmc_pkg::MODE_IDLE)
                        begin
                            elapsed_next = '0;
                            clear_next   = 1'b1;
                            mode_next    = trmc_pkg::MODE_RUNNING;
                            rem_ms_next  = duration_reg;
                        end
                        else
                        begin
                            mode_next = trmc_pkg::MODE_IDLE;
                        end
                    end
                    trmc_pkg::OP_HOME:
                    begin
                        mode_next  = trmc_pkg::MODE_HOMING;
                        home_next  = 1'b0;
                        drive_next = home_drive_reg;
                    end
                    trmc_pkg::OP_ABORT:
                    begin
                        mode_next = trmc_pkg::MODE_IDLE;
                    end
                    default:
                    begin
                        mode_next = trmc_pkg::MODE_IDLE;
                    end
                endcase
            end
            trmc_pkg::UOP_EMIT:
            begin
                if (!status.out_busy)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {7'd0, rem_ms_reg, tgt_reg, fin_reg, clear_reg,
                                     home_reg, mode_reg, drive_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg   <= trmc_pkg::DURATION_RST;
            threshold_reg  <= trmc_pkg::THRESHOLD_RST;
            min_drive_reg  <= trmc_pkg::MIN_DRIVE_RST;
            gain_reg       <= trmc_pkg::GAIN_RST;
            home_drive_reg <= trmc_pkg::HOME_DRV_RST;
            ticks_reg      <= trmc_pkg::TICKS_RST;
            mode_reg       <= trmc_pkg::MODE_IDLE;
            home_reg       <= 1'b0;
            elapsed_reg    <= '0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            home_reg     <= home_next;
            elapsed_reg  <= elapsed_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    trmc_pkg::REG_DURATION:  duration_reg   <= cfg_wdata[trmc_pkg::DUR_W-1:0];
                    trmc_pkg::REG_THRESHOLD: threshold_reg  <= cfg_wdata[trmc_pkg::THR_W-1:0];
                    trmc_pkg::REG_MIN_DRIVE: min_drive_reg  <= cfg_wdata[trmc_pkg::DRV_W-1:0];
                    trmc_pkg::REG_GAIN:      gain_reg       <= cfg_wdata[trmc_pkg::GAIN_W-1:0];
                    trmc_pkg::REG_HOME_DRV:  home_drive_reg <= cfg_wdata[trmc_pkg::DRV_W-1:0];
                    trmc_pkg::REG_TICKS:     ticks_reg      <= cfg_wdata[trmc_pkg::TPR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        enc_reg      <= enc_next;
        sen_reg      <= sen_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        err_reg      <= err_next;
        lag_reg      <= lag_next;
        drive_reg    <= drive_next;
        clear_reg    <= clear_next;
        fin_reg      <= fin_next;
        tgt_reg      <= tgt_next;
        rem_ms_reg   <= rem_ms_next;
        out_data_reg <= out_data_next;
    end

endmodule
